### hw/rtl/fbms_pkg.sv
// shared types, constants and scoring functions for the fuzzy best-match search unit
`timescale 1ns / 1ps

package fbms_pkg;

    localparam int MAX_QUERY = 64;
    localparam int MAX_WORD  = 64;
    localparam int MAX_WORDS = 1024;

    localparam int QADDR_W = $clog2(MAX_QUERY);
    localparam int QLEN_W  = $clog2(MAX_QUERY + 1);
    localparam int WLEN_W  = $clog2(MAX_WORD + 1);
    localparam int WIDX_W  = $clog2(MAX_WORDS);

    localparam int SYM_W   = 8;
    localparam int SCORE_W = 11;
    localparam int PEN_W   = 5;
    localparam int NUM_W   = 10;

    localparam logic [QLEN_W-1:0] QLEN_MAX  = QLEN_W'(MAX_QUERY);
    localparam logic [WLEN_W-1:0] WLEN_MAX  = WLEN_W'(MAX_WORD);
    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(MAX_WORDS - 1);

    localparam logic signed [SCORE_W:0] SCORE_HI  = 12'sd1023;
    localparam logic signed [SCORE_W:0] SCORE_LO  = -12'sd1024;
    localparam logic signed [SCORE_W:0] ADD_LEAD  = 12'sd10;
    localparam logic signed [SCORE_W:0] ADD_RUN   = 12'sd5;
    localparam logic signed [SCORE_W:0] ADD_MISS  = -12'sd1;
    localparam logic signed [PEN_W:0]   PEN_STEP  = -6'sd3;
    localparam logic signed [PEN_W:0]   PEN_FLOOR = -6'sd9;

    localparam logic [SYM_W-1:0] SEP_MAX   = 8'd32;
    localparam logic [SYM_W-1:0] FOLD_MASK = 8'hDF;
    localparam int               LEAD_BIT  = 6;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_CAND   = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    typedef enum logic {
        KIND_WORD    = 1'b0,
        KIND_OUTCOME = 1'b1
    } kind_t;

    typedef struct packed {
        action_t          action;
        logic [SYM_W-1:0] symbol;
        logic             word_end;
    } item_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [SCORE_W-1:0] word_score;
        logic [NUM_W-1:0]          word_number;
        logic                      found;
    } result_t;

    typedef struct packed {
        logic [QLEN_W-1:0]         pos;
        logic [SYM_W-1:0]          prev;
        logic                      run;
        logic signed [SCORE_W-1:0] score;
        logic signed [PEN_W-1:0]   pen;
    } word_st_t;

    typedef struct packed {
        logic               en;
        logic [QADDR_W-1:0] addr;
        logic [SYM_W-1:0]   data;
    } qwrite_t;

    function automatic logic signed [SCORE_W-1:0] sat_score(logic signed [SCORE_W:0] v);
        logic signed [SCORE_W-1:0] r;
        if (v > SCORE_HI)
            r = SCORE_HI[SCORE_W-1:0];
        else if (v < SCORE_LO)
            r = SCORE_LO[SCORE_W-1:0];
        else
            r = v[SCORE_W-1:0];
        return r;
    endfunction

    // one greedy comparison of a word byte against the current query byte
    function automatic word_st_t score_step(word_st_t st, logic [SYM_W-1:0] c,
                                            logic [SYM_W-1:0] nxt, logic [SYM_W-1:0] q,
                                            logic [QLEN_W-1:0] qlen);
        word_st_t                  r;
        logic                      lead;
        logic signed [SCORE_W:0]   s_ext;
        logic signed [SCORE_W:0]   add;
        logic signed [PEN_W:0]     p;
        r     = st;
        lead  = c[LEAD_BIT] & ~nxt[LEAD_BIT];
        s_ext = (SCORE_W+1)'(st.score);
        p     = (PEN_W+1)'(st.pen);
        if (st.pos < qlen)
        begin
            if ((c & FOLD_MASK) == (q & FOLD_MASK))
            begin
                if (st.prev <= SEP_MAX || lead)
                    add = ADD_LEAD;
                else if (st.run)
                    add = ADD_RUN;
                else
                    add = '0;
                r.run   = 1'b1;
                r.score = sat_score(s_ext + add);
                r.pos   = st.pos + 1'b1;
            end
            else
            begin
                r.run   = 1'b0;
                r.score = sat_score(s_ext + ADD_MISS);
                if (lead)
                begin
                    p     = p + PEN_STEP;
                    r.pen = (p < PEN_FLOOR) ? PEN_FLOOR[PEN_W-1:0] : p[PEN_W-1:0];
                end
            end
        end
        r.prev = c;
        return r;
    endfunction

endpackage

### hw/rtl/fbms_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module fbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hw/rtl/fbms_core.sv
// word scoring state, best-word tracking and query bookkeeping
`timescale 1ns / 1ps

module fbms_core import fbms_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  item_t             item,
    input  logic [SYM_W-1:0]  q_cur,
    input  logic [SYM_W-1:0]  q_nxt,
    output logic [QLEN_W-1:0] pos_next,
    output qwrite_t           qwr,
    output logic              res_valid,
    output result_t           res
);

    logic [QLEN_W-1:0]         qlen_reg, qlen_next;
    word_st_t                  ws_reg, ws_next;
    logic [SYM_W-1:0]          held_reg, held_next;
    logic                      held_valid_reg, held_valid_next;
    logic [WLEN_W-1:0]         wlen_reg, wlen_next;
    logic [WIDX_W-1:0]         widx_reg, widx_next;
    logic signed [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [WIDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [WLEN_W-1:0]         best_len_reg, best_len_next;
    logic                      best_valid_reg, best_valid_next;

    word_st_t                  st1, st2;
    logic [SYM_W-1:0]          q2;
    logic [WLEN_W-1:0]         wlen_inc;
    logic signed [SCORE_W:0]   tot_ext;
    logic signed [SCORE_W-1:0] total;
    logic                      take_best;

    always_comb
    begin
        st1      = held_valid_reg ? score_step(ws_reg, held_reg, item.symbol, q_cur, qlen_reg)
                                  : ws_reg;
        q2       = (st1.pos != ws_reg.pos) ? q_nxt : q_cur;
        st2      = score_step(st1, item.symbol, '0, q2, qlen_reg);
        wlen_inc = (wlen_reg < WLEN_MAX) ? wlen_reg + 1'b1 : wlen_reg;
        tot_ext  = (SCORE_W+1)'(st2.score) + (SCORE_W+1)'(st2.pen);
        total    = sat_score(tot_ext);
        take_best = (total > best_score_reg)
                 || ((total == best_score_reg) && !(best_valid_reg && best_len_reg < wlen_inc));
    end

    always_comb
    begin
        qlen_next       = qlen_reg;
        ws_next         = ws_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        wlen_next       = wlen_reg;
        widx_next       = widx_reg;
        best_score_next = best_score_reg;
        best_idx_next   = best_idx_reg;
        best_len_next   = best_len_reg;
        best_valid_next = best_valid_reg;
        qwr.en          = 1'b0;
        qwr.addr        = qlen_reg[QADDR_W-1:0];
        qwr.data        = item.symbol;
        res_valid       = 1'b0;
        res.kind        = KIND_WORD;
        res.word_score  = total;
        res.word_number = NUM_W'(widx_reg);
        res.found       = 1'b0;
        if (take)
        begin
            case (item.action)
                ACT_CLEAR:
                begin
                    qlen_next = '0;
                end
                ACT_APPEND:
                begin
                    if (qlen_reg < QLEN_MAX)
                    begin
                        qwr.en    = 1'b1;
                        qlen_next = qlen_reg + 1'b1;
                    end
                end
                ACT_CAND:
                begin
                    wlen_next = wlen_inc;
                    if (!item.word_end)
                    begin
                        ws_next         = st1;
                        held_next       = item.symbol;
                        held_valid_next = 1'b1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        if (take_best)
                        begin
                            best_score_next = total;
                            best_idx_next   = widx_reg;
                            best_len_next   = wlen_inc;
                            best_valid_next = 1'b1;
                        end
                        if (widx_reg < WIDX_LAST)
                            widx_next = widx_reg + 1'b1;
                        ws_next         = '0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        wlen_next       = '0;
                    end
                end
                ACT_FINISH:
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_OUTCOME;
                    res.word_score  = best_valid_reg ? best_score_reg : '0;
                    res.word_number = best_valid_reg ? NUM_W'(best_idx_reg) : '0;
                    res.found       = best_valid_reg;
                    ws_next         = '0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    wlen_next       = '0;
                    widx_next       = '0;
                    best_score_next = '0;
                    best_idx_next   = '0;
                    best_len_next   = '0;
                    best_valid_next = 1'b0;
                end
                default:
                begin
                    qlen_next = qlen_reg;
                end
            endcase
        end
        pos_next = ws_next.pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg       <= '0;
            ws_reg         <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            wlen_reg       <= '0;
            widx_reg       <= '0;
            best_score_reg <= '0;
            best_idx_reg   <= '0;
            best_len_reg   <= '0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            qlen_reg       <= qlen_next;
            ws_reg         <= ws_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            wlen_reg       <= wlen_next;
            widx_reg       <= widx_next;
            best_score_reg <= best_score_next;
            best_idx_reg   <= best_idx_next;
            best_len_reg   <= best_len_next;
            best_valid_reg <= best_valid_next;
        end
    end

endmodule

### hw/rtl/fuzzy_best_match_search_unit.sv
// top level of the fuzzy best-match search unit
//
// channel   dir   tdata                                  tuser    tlast
// s_*       in    symbol[7:0]                            action   word_end
// m_*       out   word_score[10:0] word_number[20:11]    kind     -
//                 found[21], zero pad to 24 bits
//
// one request per cycle in while s_tready is high, at most one result per request, results registered
// query bytes sit in a 64-entry ram read at the current and next query position
// a two-entry output buffer keeps s_tready registered; it drops only while both are full
// rst_n is asynchronous and clears the query length, word state and best-word record
`timescale 1ns / 1ps

module fuzzy_best_match_search_unit import fbms_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // symbol
    input  logic [1:0]  s_tuser,    // action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // word_score, word_number, found
    output logic [0:0]  m_tuser     // kind
);

    item_t              item;
    logic               take;
    logic [QLEN_W-1:0]  pos_next;
    qwrite_t            qwr;
    logic               res_valid;
    result_t            res;
    logic [QADDR_W-1:0] ra_a, ra_b;
    logic [SYM_W-1:0]   rd_a, rd_b;
    logic [SYM_W-1:0]   q_cur, q_nxt;

    logic               hit_a_reg, hit_b_reg;
    logic [SYM_W-1:0]   byp_reg;

    logic               out_valid_reg, skid_valid_reg;
    result_t            out_reg, skid_reg;
    logic               push, out_free;

    assign item.action   = action_t'(s_tuser);
    assign item.symbol   = s_tdata;
    assign item.word_end = s_tlast;
    assign s_tready      = !skid_valid_reg;
    assign take          = s_tvalid && s_tready;

    fbms_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .q_cur     (q_cur),
        .q_nxt     (q_nxt),
        .pos_next  (pos_next),
        .qwr       (qwr),
        .res_valid (res_valid),
        .res       (res)
    );

    assign ra_a = pos_next[QADDR_W-1:0];
    assign ra_b = ra_a + 1'b1;

    fbms_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_QUERY)
    ) u_query_ram (
        .clk     (clk),
        .we      (qwr.en),
        .waddr   (qwr.addr),
        .wdata   (qwr.data),
        .raddr_a (ra_a),
        .raddr_b (ra_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // same-cycle write forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            hit_a_reg <= qwr.en && (qwr.addr == ra_a);
            hit_b_reg <= qwr.en && (qwr.addr == ra_b);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_reg <= qwr.data;
    end

    assign q_cur = hit_a_reg ? byp_reg : rd_a;
    assign q_nxt = hit_b_reg ? byp_reg : rd_b;

    // output register plus skid entry
    assign push     = take && res_valid;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (push)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.found, out_reg.word_number, out_reg.word_score};
    assign m_tuser  = out_reg.kind;

endmodule

### hw/rtl/fbms_checker.sv
// port-level checks for the fuzzy best-match search unit, bound to the top level
`timescale 1ns / 1ps

module fbms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // word score results never carry found
    a_word_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tdata[21])
        else $error("word result with found set");

    // outcome without a best word is all zero
    a_empty_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && !m_tdata[21] |-> m_tdata[20:0] == 21'd0)
        else $error("empty outcome not zero");

    // a found best score is never negative
    a_best_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tdata[21] |-> !m_tdata[10])
        else $error("negative best score");

    // a result appears only in the cycle after an accepted request or while held
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(s_tvalid && s_tready) && !$past(m_tvalid) |-> !m_tvalid)
        else $error("result without request");

endmodule

bind fuzzy_best_match_search_unit fbms_checker u_fbms_checker (.*);
